FILE: rtl/fic_pkg.sv
package fic_pkg;

  localparam int LENGTH_BITS = 24;

  localparam logic [31:0] CRC_INIT = 32'hFFFF_FFFF;
  localparam logic [31:0] CRC_POLY = 32'h04C1_1DB7;

  typedef enum logic [1:0] {
    MODE_MARK     = 2'd0,
    MODE_VERIFY   = 2'd1,
    MODE_ROLLBACK = 2'd2
  } mode_t;

  typedef enum logic [1:0] {
    STATUS_OK           = 2'd0,
    STATUS_INVALID      = 2'd1,
    STATUS_CRC_MISMATCH = 2'd2,
    STATUS_LEN_MISMATCH = 2'd3
  } status_t;

  // one input item as held in the input register
  typedef struct packed {
    logic [1:0] mode;
    logic       bank;
    logic [7:0] data;
    logic       last;
  } in_item_t;

  // MSB-first CRC-32 update by one byte, eight shift steps unrolled
  function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b);
    logic [31:0] c;
    c = crc ^ {b, 24'd0};
    for (int k = 0; k < 8; k++) begin
      if (c[31]) begin
        c = {c[30:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[30:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

FILE: rtl/fic_in_stage.sv
module fic_in_stage (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  fic_pkg::in_item_t in_item,
  output logic              s1_valid,
  input  logic              s1_ready,
  output fic_pkg::in_item_t s1_item
);
  import fic_pkg::*;

  logic     s1_valid_r;
  logic     s1_valid_nxt;
  in_item_t s1_item_r;

  assign in_ready = !s1_valid_r || s1_ready;

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_ready) begin
      s1_valid_nxt = in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
    end
  end

  // payload: load on every accepted item
  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      s1_item_r <= in_item;
    end
  end

  assign s1_valid = s1_valid_r;
  assign s1_item  = s1_item_r;

endmodule

FILE: rtl/fic_core.sv
module fic_core (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              s1_valid,
  output logic              s1_ready,
  input  fic_pkg::in_item_t s1_item,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [1:0]        out_status,
  output logic              out_ok,
  output logic [31:0]       out_crc
);
  import fic_pkg::*;

  // bank records
  logic [1:0]             image_valid_r;
  logic [1:0]             image_valid_nxt;
  logic [31:0]            image_crc_r [2];
  logic [LENGTH_BITS-1:0] image_length_r [2];

  // shared stream state
  logic [31:0]            running_crc_r;
  logic [31:0]            running_crc_nxt;
  logic [LENGTH_BITS-1:0] byte_count_r;
  logic [LENGTH_BITS-1:0] byte_count_nxt;

  // result register
  logic        out_valid_r;
  logic        out_valid_nxt;
  logic [1:0]  out_status_r;
  logic        out_ok_r;
  logic [31:0] out_crc_r;

  logic                   is_stream;
  logic                   is_rollback;
  logic                   has_result;
  logic                   out_free;
  logic                   fire;
  logic [31:0]            crc_upd;
  logic [31:0]            crc_final;
  logic [LENGTH_BITS-1:0] cnt_inc;
  status_t                status;
  logic                   ok;
  logic [31:0]            crc_res;
  logic                   store_rec;

  always_comb begin
    is_stream   = 1'b0;
    is_rollback = 1'b0;
    case (mode_t'(s1_item.mode))
      MODE_MARK:     is_stream = 1'b1;
      MODE_VERIFY:   is_stream = 1'b1;
      MODE_ROLLBACK: is_rollback = 1'b1;
      default: begin
        is_stream   = 1'b0;
        is_rollback = 1'b0;
      end
    endcase
  end

  assign has_result = is_rollback || (is_stream && s1_item.last);
  assign out_free   = !out_valid_r || out_ready;
  // an item with no result never waits on the output side
  assign fire       = s1_valid && (!has_result || out_free);
  assign s1_ready   = !has_result || out_free;

  assign crc_upd   = crc_byte(running_crc_r, s1_item.data);
  assign crc_final = crc_upd ^ CRC_INIT;
  assign cnt_inc   = byte_count_r + LENGTH_BITS'(1);

  always_comb begin
    status    = STATUS_OK;
    ok        = 1'b1;
    crc_res   = crc_final;
    store_rec = 1'b0;
    if (is_rollback) begin
      crc_res = 32'd0;
    end else if (mode_t'(s1_item.mode) == MODE_MARK) begin
      store_rec = 1'b1;
    end else if (!image_valid_r[s1_item.bank]) begin
      status = STATUS_INVALID;
      ok     = 1'b0;
    end else if (crc_final != image_crc_r[s1_item.bank]) begin
      status = STATUS_CRC_MISMATCH;
      ok     = 1'b0;
    end else if (cnt_inc != image_length_r[s1_item.bank]) begin
      status = STATUS_LEN_MISMATCH;
      ok     = 1'b0;
    end
  end

  always_comb begin
    running_crc_nxt = running_crc_r;
    byte_count_nxt  = byte_count_r;
    image_valid_nxt = image_valid_r;
    if (fire && is_stream) begin
      if (s1_item.last) begin
        running_crc_nxt = CRC_INIT;
        byte_count_nxt  = '0;
      end else begin
        running_crc_nxt = crc_upd;
        byte_count_nxt  = cnt_inc;
      end
    end
    if (fire && is_rollback) begin
      image_valid_nxt[s1_item.bank] = 1'b0;
    end
    if (fire && has_result && store_rec) begin
      image_valid_nxt[s1_item.bank] = 1'b1;
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (fire && has_result) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      image_valid_r <= '0;
      running_crc_r <= CRC_INIT;
      byte_count_r  <= '0;
      out_valid_r   <= 1'b0;
    end else begin
      image_valid_r <= image_valid_nxt;
      running_crc_r <= running_crc_nxt;
      byte_count_r  <= byte_count_nxt;
      out_valid_r   <= out_valid_nxt;
    end
  end

  // records are only read after the valid flag is set
  always_ff @(posedge clk) begin
    if (fire && has_result && store_rec) begin
      image_crc_r[s1_item.bank]    <= crc_final;
      image_length_r[s1_item.bank] <= cnt_inc;
    end
  end

  always_ff @(posedge clk) begin
    if (fire && has_result) begin
      out_status_r <= status;
      out_ok_r     <= ok;
      out_crc_r    <= crc_res;
    end
  end

  assign out_valid  = out_valid_r;
  assign out_status = out_status_r;
  assign out_ok     = out_ok_r;
  assign out_crc    = out_crc_r;

endmodule

FILE: rtl/firmware_image_crc_checker_top.sv
// Channel | Signals                          | Carries
// in_     | tvalid tready tdata tuser tlast  | image byte, mode and bank, final-byte mark
// out_    | tvalid tready tdata tuser        | CRC of the image, status and pass flag
//
// One item is taken every cycle unless out_ stalls; results pass input and result registers.
// The CRC update is an eight-step byte unroll between the input and result registers.
// Reset clears both bank valid flags and the byte count and sets the running CRC to CRC_INIT.
// A stall on out_ holds an item that yields a result and the input behind it;
// items with no result pass a full result register.
module firmware_image_crc_checker_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] image_byte
  input  logic [2:0]  in_tuser,   // [1:0] mode, [2] bank
  input  logic        in_tlast,   // last_byte
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // [31:0] crc_value
  output logic [2:0]  out_tuser   // [1:0] status, [2] image_ok
);
  import fic_pkg::*;

  in_item_t   in_item;
  in_item_t   s1_item;
  logic       s1_valid;
  logic       s1_ready;
  logic [1:0] status;
  logic       ok;

  assign in_item.mode = in_tuser[1:0];
  assign in_item.bank = in_tuser[2];
  assign in_item.data = in_tdata;
  assign in_item.last = in_tlast;

  fic_in_stage u_in (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_ready (in_tready),
    .in_item  (in_item),
    .s1_valid (s1_valid),
    .s1_ready (s1_ready),
    .s1_item  (s1_item)
  );

  fic_core u_core (
    .clk        (clk),
    .rst_n      (rst_n),
    .s1_valid   (s1_valid),
    .s1_ready   (s1_ready),
    .s1_item    (s1_item),
    .out_valid  (out_tvalid),
    .out_ready  (out_tready),
    .out_status (status),
    .out_ok     (ok),
    .out_crc    (out_tdata)
  );

  assign out_tuser = {ok, status};

endmodule

FILE: rtl/fic_checker.sv
module fic_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [31:0] out_tdata,
  input logic [2:0]  out_tuser
);
  import fic_pkg::*;

  // pass flag and ok status always agree
  a_ok_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tuser[2] == (out_tuser[1:0] == STATUS_OK)))
    else $error("image_ok disagrees with status");

  // nothing comes out right after reset
  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid right after reset");

  a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("result dropped while stalled");

  a_hold_data: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> $stable(out_tdata) && $stable(out_tuser))
    else $error("result changed while stalled");

endmodule

bind firmware_image_crc_checker_top fic_checker u_fic_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);

FILE: bench/firmware_image_crc_checker_top_tb.sv
module firmware_image_crc_checker_top_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import fic_pkg::*;

  localparam logic [1:0] MODE_UNUSED = 2'd3;
  localparam int QUIET_LIMIT = 1000;
  localparam int DRAIN_CYCLES = 8;
  localparam int IMG_DEPTH = 64;

  typedef struct packed {
    status_t     status;
    logic        ok;
    logic [31:0] crc;
  } integrity_result_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata = '0;   // [7:0] image_byte
  logic [2:0]  in_tuser = '0;   // [1:0] mode, [2] bank
  logic        in_tlast = 1'b0; // last_byte
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [31:0] out_tdata;       // [31:0] crc_value
  logic [2:0]  out_tuser;       // [1:0] status, [2] image_ok

  // predicted state of the checker
  logic                   bank_valid[2];
  logic [31:0]            bank_crc[2];
  logic [LENGTH_BITS-1:0] bank_len[2];
  logic [31:0]            run_crc;
  logic [LENGTH_BITS-1:0] run_len;
  integrity_result_t      pending_reports[$];

  // stimulus side view of the open stream and the marked images
  logic [31:0] gen_run = CRC_INIT;
  int          open_n = 0;
  logic [7:0]  open_buf[IMG_DEPTH];
  logic [31:0] marked_raw[2] = '{CRC_INIT, CRC_INIT};
  int          marked_n[2] = '{0, 0};
  logic [7:0]  marked_img[2][IMG_DEPTH];

  bit gaps_on = 1'b1;
  int items_sent = 0;
  int n_errors = 0;
  int quiet_cycles = 0;

  firmware_image_crc_checker_top i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  // MSB-first CRC-32, one data bit per shift
  function automatic logic [31:0] crc_feed(input logic [31:0] c, input logic [7:0] d);
    logic [31:0] r;
    logic        fb;
    r = c;
    for (int i = 7; i >= 0; i--) begin
      fb = r[31] ^ d[i];
      r = {r[30:0], 1'b0} ^ (fb ? CRC_POLY : 32'd0);
    end
    return r;
  endfunction

  // undo 32 zero-bit shifts; the polynomial is odd, so bit 0 recovers the feedback
  function automatic logic [31:0] crc_unwind32(input logic [31:0] c);
    logic [31:0] r;
    logic        top;
    r = c;
    repeat (32) begin
      top = r[0];
      if (top) begin
        r = r ^ CRC_POLY;
      end
      r = {top, r[31:1]};
    end
    return r;
  endfunction

  task automatic predict_item(input logic [1:0] mode, input logic bank, input logic [7:0] data,
                              input logic last);
    integrity_result_t r;
    case (mode)
      MODE_ROLLBACK: begin
        bank_valid[bank] = 1'b0;
        r.status = STATUS_OK;
        r.ok = 1'b1;
        r.crc = '0;
        pending_reports.push_back(r);
      end
      MODE_MARK, MODE_VERIFY: begin
        run_crc = crc_feed(run_crc, data);
        run_len = run_len + 1'b1;
        if (last) begin
          r.crc = run_crc ^ CRC_INIT;
          r.ok = 1'b0;
          if (mode == MODE_MARK) begin
            bank_crc[bank] = r.crc;
            bank_len[bank] = run_len;
            bank_valid[bank] = 1'b1;
            r.status = STATUS_OK;
            r.ok = 1'b1;
          end else if (!bank_valid[bank]) begin
            r.status = STATUS_INVALID;
          end else if (r.crc != bank_crc[bank]) begin
            r.status = STATUS_CRC_MISMATCH;
          end else if (run_len != bank_len[bank]) begin
            r.status = STATUS_LEN_MISMATCH;
          end else begin
            r.status = STATUS_OK;
            r.ok = 1'b1;
          end
          run_crc = CRC_INIT;
          run_len = '0;
          pending_reports.push_back(r);
        end
      end
      default: begin
      end
    endcase
  endtask

  task automatic check_report(input logic [1:0] status, input logic ok, input logic [31:0] crc);
    integrity_result_t want;
    if (pending_reports.size() == 0) begin
      $error("result with none expected: status %0d image_ok %0d crc_value %h", status, ok, crc);
      n_errors++;
    end else begin
      want = pending_reports.pop_front();
      if (status !== want.status) begin
        $error("status: expected %0d, got %0d", want.status, status);
        n_errors++;
      end
      if (ok !== want.ok) begin
        $error("image_ok: expected %0d, got %0d", want.ok, ok);
        n_errors++;
      end
      if (crc !== want.crc) begin
        $error("crc_value: expected %h, got %h", want.crc, crc);
        n_errors++;
      end
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      bank_valid = '{1'b0, 1'b0};
      bank_crc = '{32'd0, 32'd0};
      bank_len = '{'0, '0};
      run_crc = CRC_INIT;
      run_len = '0;
    end else begin
      if (in_tvalid && in_tready) begin
        predict_item(in_tuser[1:0], in_tuser[2], in_tdata, in_tlast);
      end
      if (out_tvalid && out_tready) begin
        check_report(out_tuser[1:0], out_tuser[2], out_tdata);
      end
    end
  end

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles == QUIET_LIMIT) begin
      $display("no item moved for %0d cycles", QUIET_LIMIT);
      $display("Mismatches found");
      $finish;
    end
  end

  // result side back-pressure
  initial begin
    @(posedge clk);
    forever begin
      if (gaps_on && $urandom_range(0, 3) == 0) begin
        out_tready <= 1'b0;
        repeat ($urandom_range(1, 18)) @(posedge clk);
      end
      out_tready <= 1'b1;
      repeat ($urandom_range(1, 24)) @(posedge clk);
    end
  end

  task automatic send_item(input logic [1:0] mode, input logic bank, input logic [7:0] data,
                           input logic last);
    if (gaps_on && $urandom_range(0, 3) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 18)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= data;
    in_tuser <= {bank, mode};
    in_tlast <= last;
    do @(posedge clk); while (!in_tready);
    if (mode != MODE_UNUSED) begin
      items_sent++;
    end
    // track the open stream so later items can replay or forge against it
    if (mode == MODE_MARK || mode == MODE_VERIFY) begin
      if (open_n < IMG_DEPTH) begin
        open_buf[open_n] = data;
      end
      open_n++;
      gen_run = crc_feed(gen_run, data);
      if (last) begin
        if (mode == MODE_MARK) begin
          marked_raw[bank] = gen_run;
          marked_n[bank] = (open_n > IMG_DEPTH) ? IMG_DEPTH : open_n;
          for (int i = 0; i < marked_n[bank]; i++) begin
            marked_img[bank][i] = open_buf[i];
          end
        end
        gen_run = CRC_INIT;
        open_n = 0;
      end
    end
  endtask

  task automatic send_bytes(input logic [1:0] mode, input logic bank, input int n, input bit close);
    for (int i = 0; i < n; i++) begin
      send_item(mode, bank, 8'($urandom_range(0, 255)), close && i == n - 1);
    end
  endtask

  task automatic replay_image(input logic bank, input bit corrupt);
    int         n;
    int         spot;
    logic [7:0] b;
    logic [7:0] flip;
    n = marked_n[bank];
    if (n == 0) begin
      send_item(MODE_VERIFY, bank, 8'($urandom_range(0, 255)), 1'b1);
    end else begin
      spot = $urandom_range(0, n - 1);
      flip = 8'($urandom_range(1, 255));
      for (int i = 0; i < n; i++) begin
        b = marked_img[bank][i];
        if (corrupt && i == spot) begin
          b = b ^ flip;
        end
        send_item(MODE_VERIFY, bank, b, i == n - 1);
      end
    end
  endtask

  // append four bytes that steer the CRC onto the bank's stored value
  task automatic forge_length(input logic bank, input int pre);
    logic [31:0] word;
    send_bytes(MODE_VERIFY, bank, pre, 1'b0);
    word = gen_run ^ crc_unwind32(marked_raw[bank]);
    for (int i = 3; i >= 0; i--) begin
      send_item(MODE_VERIFY, bank, word[8*i +: 8], i == 0);
    end
  endtask

  task automatic test_unwritten_banks;
    send_item(MODE_VERIFY, 1'b0, 8'h00, 1'b1);
    send_item(MODE_ROLLBACK, 1'b1, 8'hFF, 1'b1);
    send_item(MODE_VERIFY, 1'b1, 8'hFF, 1'b1);
  endtask

  task automatic test_mark_verify;
    send_item(MODE_MARK, 1'b0, 8'h00, 1'b1);
    send_item(MODE_VERIFY, 1'b0, 8'h00, 1'b1);
    send_item(MODE_VERIFY, 1'b0, 8'hFF, 1'b1);
    // unused mode in the middle of a stream is dropped
    send_item(MODE_MARK, 1'b1, 8'hFF, 1'b0);
    send_item(MODE_UNUSED, 1'b0, 8'hA5, 1'b1);
    send_item(MODE_MARK, 1'b1, 8'h00, 1'b1);
    // the final byte's bank decides, even with a stream started on the other bank
    send_item(MODE_VERIFY, 1'b0, 8'hFF, 1'b0);
    send_item(MODE_VERIFY, 1'b1, 8'h00, 1'b1);
  endtask

  task automatic test_rollback;
    send_item(MODE_VERIFY, 1'b1, 8'hFF, 1'b0);
    send_item(MODE_ROLLBACK, 1'b1, 8'h3C, 1'b0);
    send_item(MODE_VERIFY, 1'b1, 8'h00, 1'b1);
    send_item(MODE_ROLLBACK, 1'b0, 8'h00, 1'b1);
    replay_image(1'b0, 1'b0);
  endtask

  task automatic test_length_mismatch;
    send_item(MODE_MARK, 1'b0, 8'h5A, 1'b1);
    forge_length(1'b0, 1);
  endtask

  task automatic test_random_traffic(input int n);
    int   stop;
    int   kind;
    int   len;
    logic bank;
    stop = items_sent + n;
    while (items_sent < stop) begin
      kind = $urandom_range(0, 99);
      bank = 1'($urandom_range(0, 1));
      len = $urandom_range(1, 12);
      if (kind < 25) begin
        if ($urandom_range(0, 9) == 0) begin
          len = $urandom_range(13, 40);
        end
        send_bytes(MODE_MARK, bank, len, 1'b1);
      end else if (kind < 45) begin
        replay_image(bank, 1'b0);
      end else if (kind < 55) begin
        replay_image(bank, 1'b1);
      end else if (kind < 65) begin
        forge_length(bank, $urandom_range(0, 3));
      end else if (kind < 75) begin
        send_bytes(MODE_VERIFY, bank, len, 1'b1);
      end else if (kind < 83) begin
        send_item(MODE_ROLLBACK, bank, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
      end else if (kind < 93 && open_n < 8) begin
        // leave a stream open for the next sequence to inherit
        send_bytes(2'($urandom_range(MODE_MARK, MODE_VERIFY)), bank, $urandom_range(1, 4), 1'b0);
      end else begin
        send_item(2'($urandom_range(MODE_MARK, MODE_UNUSED)), bank, 8'($urandom_range(0, 255)),
                  open_n >= 8 || $urandom_range(0, 1) != 0);
      end
    end
  endtask

  task automatic test_back_to_back(input int n);
    gaps_on = 1'b0;
    test_random_traffic(n);
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_unwritten_banks;
    test_mark_verify;
    test_rollback;
    test_length_mismatch;
    test_random_traffic(1130);
    test_back_to_back(280);
    in_tvalid <= 1'b0;
    while (pending_reports.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (n_errors == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
